// ----- hdl/frs_pkg.sv -----
// Shared types, codes and the CRC-8 step for the framed serial receiver.
package frs_pkg;

	// Inter-byte gap counter width (saturating).
	localparam int GAP_COUNTER_BITS = 16;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CRC_POLY  = 8'h8C;
	localparam logic [7:0] HDR_BYTE  = 8'h4B; // 'K'
	localparam logic [7:0] HDR_REPLY = 8'h6B; // 'k'
	localparam logic [7:0] FTR_BYTE  = 8'h58; // 'X'
	localparam logic [7:0] FTR_REPLY = 8'h78; // 'x'

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_DATA,
		PH_CHECK,
		PH_FOOTER
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_HEADER = 3'd1,
		ST_BAD_CHECK  = 3'd2,
		ST_BAD_FOOTER = 3'd3,
		ST_TIMEOUT    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		REG_CHECK_ENABLE = 3'd0,
		REG_NONBLOCKING  = 3'd1,
		REG_GAP_LIMIT    = 3'd2,
		REG_OK_CODE      = 3'd3,
		REG_FAIL_CODE    = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	// One result word.
	typedef struct packed {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic       reply_valid;
		logic [7:0] reply_byte;
		logic       frame_done;
		logic [2:0] status;
	} result_t;

	// Queue status seen by front and back.
	typedef struct packed {
		logic room;
		logic avail;
	} q_stat_t;

	// Reflected CRC-8, poly 0x8C, one byte.
	function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] d_in);
		logic [7:0] c;
		logic [7:0] d;
		logic       mix;
		c = crc_in;
		d = d_in;
		for (int i = 0; i < 8; i++) begin
			mix = c[0] ^ d[0];
			c = {1'b0, c[7:1]};
			if (mix) begin
				c = c ^ CRC_POLY;
			end
			d = {1'b0, d[7:1]};
		end
		return c;
	endfunction

endpackage

// ----- hdl/frs_front.sv -----
// Front part: accepts line words, runs the frame parser and builds result words.
module frs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic [7:0]          s_tdata,
	input  logic                s_tuser,
	input  logic                wr_en,
	input  logic [2:0]          wr_index,
	input  logic [15:0]         wr_data,
	input  frs_pkg::q_stat_t    q_stat,
	output logic                push,
	output frs_pkg::result_t    res
);
	import frs_pkg::*;

	localparam int GW    = GAP_COUNTER_BITS;
	localparam int CMP_W = (GW > 16) ? GW : 16;
	localparam logic [GW-1:0] GAP_MAX = {GW{1'b1}};

	logic          chk_en_q;
	logic          nb_q;
	logic [15:0]   limit_q;
	logic [7:0]    ok_code_q;
	logic [7:0]    fail_code_q;

	phase_t        phase_q, phase_d;
	logic [15:0]   len_q, len_d;
	logic [15:0]   seen_q, seen_d;
	logic [7:0]    crc_q, crc_d;
	logic [GW-1:0] gap_q, gap_d;

	logic          accept;
	logic          is_tick;
	logic          is_byte;
	logic          tick_live;
	logic          gap_ge;
	logic [15:0]   seen_inc;
	logic [7:0]    crc_next;
	phase_t        after_data;

	assign accept     = s_tvalid & q_stat.room;
	assign is_tick    = accept & (s_tuser == OP_TICK);
	assign is_byte    = accept & (s_tuser == OP_BYTE);
	assign tick_live  = is_tick & (phase_q != PH_IDLE) & nb_q;
	assign gap_ge     = CMP_W'(gap_q) >= CMP_W'(limit_q);
	assign seen_inc   = seen_q + 16'd1;
	assign crc_next   = crc8_step(crc_q, s_tdata);
	// check_enable is sampled when the data part ends
	assign after_data = chk_en_q ? PH_CHECK : PH_FOOTER;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_en_q    <= 1'b1;
			nb_q        <= 1'b0;
			limit_q     <= 16'd1000;
			ok_code_q   <= 8'd0;
			fail_code_q <= 8'd2;
		end else if (wr_en) begin
			case (wr_index)
				REG_CHECK_ENABLE: chk_en_q    <= wr_data[0];
				REG_NONBLOCKING:  nb_q        <= wr_data[0];
				REG_GAP_LIMIT:    limit_q     <= wr_data;
				REG_OK_CODE:      ok_code_q   <= wr_data[7:0];
				REG_FAIL_CODE:    fail_code_q <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	// next state and parser datapath
	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		seen_d  = seen_q;
		crc_d   = crc_q;
		gap_d   = gap_q;
		if (tick_live) begin
			if (gap_ge) begin
				phase_d = PH_IDLE;
				gap_d   = '0;
			end else if (gap_q != GAP_MAX) begin
				gap_d = gap_q + GW'(1);
			end
		end else if (is_byte) begin
			gap_d = '0;
			case (phase_q)
				PH_IDLE: begin
					if (s_tdata == HDR_BYTE) begin
						phase_d = PH_LEN_HI;
						len_d   = '0;
						seen_d  = '0;
						crc_d   = '0;
					end
				end
				PH_LEN_HI: begin
					len_d   = {s_tdata, 8'd0};
					phase_d = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_d   = {len_q[15:8], s_tdata};
					seen_d  = '0;
					phase_d = ({len_q[15:8], s_tdata} == 16'd0) ? after_data : PH_DATA;
				end
				PH_DATA: begin
					crc_d  = crc_next;
					seen_d = seen_inc;
					if (seen_inc >= len_q) begin
						phase_d = after_data;
					end
				end
				PH_CHECK: begin
					phase_d = (s_tdata != crc_q) ? PH_IDLE : PH_FOOTER;
				end
				PH_FOOTER: begin
					phase_d = PH_IDLE;
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// result word
	always_comb begin
		push = 1'b0;
		res  = '0;
		if (tick_live) begin
			if (gap_ge) begin
				push           = 1'b1;
				res.frame_done = 1'b1;
				res.status     = ST_TIMEOUT;
			end
		end else if (is_byte) begin
			case (phase_q)
				PH_IDLE: begin
					push = 1'b1;
					if (s_tdata == HDR_BYTE) begin
						res.reply_valid = 1'b1;
						res.reply_byte  = HDR_REPLY;
					end else begin
						res.frame_done = 1'b1;
						res.status     = ST_BAD_HEADER;
					end
				end
				PH_DATA: begin
					push              = 1'b1;
					res.payload_valid = 1'b1;
					res.payload_byte  = s_tdata;
				end
				PH_CHECK: begin
					push            = 1'b1;
					res.reply_valid = 1'b1;
					if (s_tdata != crc_q) begin
						res.reply_byte = fail_code_q;
						res.frame_done = 1'b1;
						res.status     = ST_BAD_CHECK;
					end else begin
						res.reply_byte = ok_code_q;
					end
				end
				PH_FOOTER: begin
					push           = 1'b1;
					res.frame_done = 1'b1;
					if (s_tdata == FTR_BYTE) begin
						res.reply_valid = 1'b1;
						res.reply_byte  = FTR_REPLY;
						res.status      = ST_OK;
					end else begin
						res.status = ST_BAD_FOOTER;
					end
				end
				default: push = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			len_q   <= '0;
			seen_q  <= '0;
			crc_q   <= '0;
			gap_q   <= '0;
		end else begin
			phase_q <= phase_d;
			len_q   <= len_d;
			seen_q  <= seen_d;
			crc_q   <= crc_d;
			gap_q   <= gap_d;
		end
	end

`ifndef SYNTHESIS
	// ticks while idle never produce a word
	a_idle_tick_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(is_tick && phase_q == PH_IDLE) |-> !push)
		else $error("tick in idle produced a result");

	// payload words carry no reply and do not end the frame
	a_payload_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(push && res.payload_valid) |-> (!res.reply_valid && !res.frame_done))
		else $error("payload word mixed with reply or end");

	// any received byte restarts the gap count
	a_gap_clear: assert property (@(posedge clk) disable iff (!arst_n)
		is_byte |=> (gap_q == '0))
		else $error("gap counter not cleared by byte");

	// frame end always leaves the parser idle
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(push && res.frame_done) |=> (phase_q == PH_IDLE))
		else $error("frame ended but parser not idle");
`endif

endmodule

// ----- hdl/frs_queue.sv -----
// Short result queue between the parser front and the output back part.
module frs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  frs_pkg::result_t push_data,
	input  logic             pop,
	output frs_pkg::result_t head,
	output frs_pkg::q_stat_t q_stat
);
	import frs_pkg::*;

	result_t                mem [QUEUE_DEPTH];
	logic [QUEUE_IDX_W-1:0] wr_ptr_q;
	logic [QUEUE_IDX_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   do_pop;

	assign q_stat.room  = count_q < QUEUE_CNT_W'(QUEUE_DEPTH);
	assign q_stat.avail = count_q != '0;
	assign do_pop       = pop & q_stat.avail;
	assign head         = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_IDX_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_IDX_W'(1);
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + QUEUE_CNT_W'(1);
				2'b01:   count_q <= count_q - QUEUE_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hdl/frs_back.sv -----
// Back part: output register that drains the queue onto the master stream.
module frs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  frs_pkg::result_t head,
	input  frs_pkg::q_stat_t q_stat,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,
	output logic [1:0]       m_tuser,
	output logic             m_tlast
);
	import frs_pkg::*;

	logic    valid_q;
	result_t word_q;

	assign pop      = q_stat.avail & (~valid_q | m_tready);
	assign m_tvalid = valid_q;
	assign m_tdata  = {5'd0, word_q.status, word_q.reply_byte, word_q.payload_byte};
	assign m_tuser  = {word_q.reply_valid, word_q.payload_valid};
	assign m_tlast  = word_q.frame_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= head;
		end
	end

endmodule

// ----- hdl/framed_serial_receiver_crc8.sv -----
// Top level of the framed serial receiver with CRC-8 check.
//
//  channel   direction  handshake          contents
//  s_*       in         s_tvalid/s_tready  tdata: line_byte; tuser: operation (0 byte, 1 tick)
//  m_*       out        m_tvalid/m_tready  tdata: payload_byte, reply_byte, status
//                                          tuser: payload_valid, reply_valid; tlast: frame_done
//  wr_*      in         wr_en              wr_index selects register, wr_data value
//
// One word per clock in while the result queue has room: the parser updates the
// frame state and CRC in the cycle a word is accepted, so a new byte or tick can
// follow in the next cycle. A result passes through the queue write and then the
// output register before m_tvalid rises, later if older results wait or m_tready is low.
// s_tready drops only when the 4-entry result queue is full, i.e. when the output
// side has stalled long enough; words that make no result still need a free slot.
// Asynchronous active-low reset returns the parser to idle and the registers to
// their defaults; no clearing pass is needed.
module framed_serial_receiver_crc8 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] line_byte
	input  logic        s_tuser,  // [0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [7:0] payload_byte, [15:8] reply_byte, [18:16] status
	output logic [1:0]  m_tuser,  // [0] payload_valid, [1] reply_valid
	output logic        m_tlast,  // frame_done
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data
);
	import frs_pkg::*;

	q_stat_t q_stat;
	result_t push_data;
	result_t head;
	logic    push;
	logic    pop;

	assign s_tready = q_stat.room;

	// byte parser, CRC and gap timer
	frs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.q_stat   (q_stat),
		.push     (push),
		.res      (push_data)
	);

	// decouples parser from output backpressure
	frs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	frs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the framed serial receiver with CRC-8 check.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import frs_pkg::*;

	localparam int CYCLE_LIMIT     = 3_000_000;
	localparam int DRAIN_CYCLES    = 8;   // result queue plus output register, with margin
	localparam int RANDOM_PHASES   = 8;
	localparam int WORDS_PER_PHASE = 228;
	localparam int REPORT_MAX      = 10;

	// Register index past the end of the map; the block must ignore writes to it.
	localparam logic [2:0] REG_SPARE = 3'd7;

	typedef enum logic [1:0] {
		ROW_WORD, // send val as given
		ROW_CRC,  // send the CRC the frame has built so far
		ROW_CFG   // register write, once the block is idle
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		op_t         op;
		logic [7:0]  val;
		logic [2:0]  reg_idx;
		logic [15:0] cfg_val;
		logic        typed;  // expected result given in the row, not by the predictor
		logic        t_has;
		result_t     t_res;
	} stim_row_t;

	// Per-phase register settings for the random part.
	localparam bit          PHASE_CHECK_EN [RANDOM_PHASES] = '{1, 1, 0, 0, 1, 0, 1, 1};
	localparam bit          PHASE_NONBLOCK [RANDOM_PHASES] = '{0, 1, 0, 1, 1, 1, 0, 1};
	localparam logic [15:0] PHASE_GAP_LIM  [RANDOM_PHASES] =
		'{16'd2, 16'd0, 16'd1000, 16'd5, 16'd65535, 16'd1, 16'd0, 16'd20};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [15:0] wr_data;

	// Receiver model: register copy
	logic        cfg_check_en;
	logic        cfg_nonblock;
	logic [15:0] cfg_gap_limit;
	logic [7:0]  cfg_ok_code;
	logic [7:0]  cfg_fail_code;

	// Receiver model: frame state
	phase_t                      rx_phase;
	logic [15:0]                 rx_len;
	logic [15:0]                 rx_count;
	logic [7:0]                  rx_crc;
	logic [GAP_COUNTER_BITS-1:0] rx_gap;

	result_t     due_results[$];   // results owed by the block, oldest first
	stim_row_t   directed_rows[$];
	int          errors = 0;
	int unsigned cycles = 0;
	bit          no_idle = 1'b0;   // suppress gaps on both sides
	int          tick_burst = 0;   // ticks still to send back to back

	framed_serial_receiver_crc8 uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic result_t frame_result(logic pv, logic [7:0] pb, logic rv,
		logic [7:0] rb, logic fd, status_t st);
		result_t r;
		r.payload_valid = pv;
		r.payload_byte  = pb;
		r.reply_valid   = rv;
		r.reply_byte    = rb;
		r.frame_done    = fd;
		r.status        = st;
		return r;
	endfunction

	function automatic string show_result(result_t r);
		return $sformatf("pv=%0b pb=%02h rv=%0b rb=%02h fd=%0b st=%0d", r.payload_valid,
			r.payload_byte, r.reply_valid, r.reply_byte, r.frame_done, r.status);
	endfunction

	function automatic void log_error(string msg);
		errors++;
		if (errors <= REPORT_MAX) begin
			$display("ERROR @%0t: %s", $realtime, msg);
		end
	endfunction

	// Reflected CRC-8, LSB first: feedback bit folds the polynomial back in.
	function automatic logic [7:0] crc8_maxim_next(logic [7:0] crc, logic [7:0] d);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ d[i];
			c  = (c >> 1) ^ (fb ? CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	// Expected behavior for one accepted word; updates the frame state.
	function automatic void parse_line_event(input op_t op, input logic [7:0] b,
		output bit has, output result_t res);
		has = 1'b0;
		res = '0;
		if (op == OP_TICK) begin
			// ticks only count inside a frame, and only in non-blocking mode
			if (rx_phase == PH_IDLE || !cfg_nonblock) begin
				return;
			end
			if (rx_gap >= cfg_gap_limit) begin
				rx_phase = PH_IDLE;
				rx_gap   = '0;
				has      = 1'b1;
				res      = frame_result(1'b0, 8'h00, 1'b0, 8'h00, 1'b1, ST_TIMEOUT);
			end else if (rx_gap != '1) begin
				rx_gap++; // saturating
			end
			return;
		end
		rx_gap = '0;
		case (rx_phase)
			PH_IDLE: begin
				has = 1'b1;
				if (b != HDR_BYTE) begin
					res = frame_result(1'b0, 8'h00, 1'b0, 8'h00, 1'b1, ST_BAD_HEADER);
				end else begin
					rx_phase = PH_LEN_HI;
					rx_len   = '0;
					rx_count = '0;
					rx_crc   = '0;
					res      = frame_result(1'b0, 8'h00, 1'b1, HDR_REPLY, 1'b0, ST_OK);
				end
			end
			PH_LEN_HI: begin
				rx_len   = {b, 8'h00};
				rx_phase = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				rx_len   = {rx_len[15:8], b};
				rx_count = '0;
				// check_enable is sampled where the data part ends
				if (rx_len == 16'd0) begin
					rx_phase = cfg_check_en ? PH_CHECK : PH_FOOTER;
				end else begin
					rx_phase = PH_DATA;
				end
			end
			PH_DATA: begin
				rx_crc = crc8_maxim_next(rx_crc, b);
				rx_count++;
				if (rx_count >= rx_len) begin
					rx_phase = cfg_check_en ? PH_CHECK : PH_FOOTER;
				end
				has = 1'b1;
				res = frame_result(1'b1, b, 1'b0, 8'h00, 1'b0, ST_OK);
			end
			PH_CHECK: begin
				has = 1'b1;
				if (b != rx_crc) begin
					rx_phase = PH_IDLE;
					res = frame_result(1'b0, 8'h00, 1'b1, cfg_fail_code, 1'b1, ST_BAD_CHECK);
				end else begin
					rx_phase = PH_FOOTER;
					res = frame_result(1'b0, 8'h00, 1'b1, cfg_ok_code, 1'b0, ST_OK);
				end
			end
			PH_FOOTER: begin
				rx_phase = PH_IDLE;
				has      = 1'b1;
				if (b != FTR_BYTE) begin
					res = frame_result(1'b0, 8'h00, 1'b0, 8'h00, 1'b1, ST_BAD_FOOTER);
				end else begin
					res = frame_result(1'b0, 8'h00, 1'b1, FTR_REPLY, 1'b1, ST_OK);
				end
			end
			default: rx_phase = PH_IDLE;
		endcase
	endfunction

	// Mostly zero, sometimes a few cycles, rarely a long pause.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Next random word, shaped by where the frame currently stands so that most
	// traffic is well-formed frames and the rest is noise, bad CRCs and ticks.
	function automatic void pick_word(output op_t op, output logic [7:0] b);
		int r;
		bit tick;
		r    = $urandom_range(0, 99);
		b    = 8'($urandom_range(0, 255));
		op   = OP_BYTE;
		tick = 1'b0;
		if (tick_burst > 0) begin
			tick_burst--;
			op = OP_TICK;
			return;
		end
		case (rx_phase)
			PH_IDLE: begin
				if (r < 80) begin
					b = HDR_BYTE;
				end else if (r >= 90) begin
					tick = 1'b1;
				end
			end
			PH_LEN_HI: begin
				// long frames only where a short timeout can cut them off
				if (r < 5) begin
					tick = 1'b1;
				end else if (!(cfg_nonblock && cfg_gap_limit <= 16'd32 && r < 15)) begin
					b = 8'h00;
				end
			end
			PH_LEN_LO: begin
				if (r < 5) begin
					tick = 1'b1;
				end else if (r < 70) begin
					b = 8'($urandom_range(0, 8));
				end else if (r < 95) begin
					b = 8'($urandom_range(9, 40));
				end
			end
			PH_DATA: begin
				if (rx_len > 16'd255 || r < 6) begin
					tick = 1'b1;
				end
			end
			PH_CHECK: begin
				if (r < 75) begin
					b = rx_crc;
				end else if (r >= 90) begin
					tick = 1'b1;
				end
			end
			PH_FOOTER: begin
				if (r < 85) begin
					b = FTR_BYTE;
				end else if (r >= 95) begin
					tick = 1'b1;
				end
			end
			default: ;
		endcase
		if (tick) begin
			op = OP_TICK;
			// bursts long enough to cross small limits now and then
			if (!cfg_nonblock) begin
				tick_burst = $urandom_range(0, 3);
			end else if (cfg_gap_limit <= 16'd20) begin
				tick_burst = $urandom_range(0, int'(cfg_gap_limit) + 2);
			end else begin
				tick_burst = $urandom_range(0, 4);
			end
		end
	endfunction

	// Present one word, wait for the handshake, then book its expected result.
	task automatic put_word(input op_t op, input logic [7:0] b, input bit typed,
		input bit t_has, input result_t t_res);
		int      gap;
		bit      has;
		result_t res;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		parse_line_event(op, b, has, res);
		if (typed) begin
			has = t_has;
			res = t_res;
		end
		if (has) begin
			due_results.push_back(res);
		end
	endtask

	// Stop sending and let every owed result, and any resultless word, clear.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (due_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		s_tvalid = 1'b0;
		wr_en    = 1'b1;
		wr_index = idx;
		wr_data  = val;
		@(negedge clk);
		wr_en = 1'b0;
		case (idx)
			REG_CHECK_ENABLE: cfg_check_en  = val[0];
			REG_NONBLOCKING:  cfg_nonblock  = val[0];
			REG_GAP_LIMIT:    cfg_gap_limit = val;
			REG_OK_CODE:      cfg_ok_code   = val[7:0];
			REG_FAIL_CODE:    cfg_fail_code = val[7:0];
			default: ;
		endcase
	endtask

	function automatic stim_row_t word_row(op_t op, logic [7:0] v, bit typed, bit t_has,
		result_t t_res);
		stim_row_t row;
		row       = '0;
		row.kind  = ROW_WORD;
		row.op    = op;
		row.val   = v;
		row.typed = typed;
		row.t_has = t_has;
		row.t_res = t_res;
		return row;
	endfunction

	function automatic stim_row_t cfg_row(logic [2:0] idx, logic [15:0] v);
		stim_row_t row;
		row         = '0;
		row.kind    = ROW_CFG;
		row.reg_idx = idx;
		row.cfg_val = v;
		return row;
	endfunction

	// Receiver side: random back-pressure, with long stalls now and then.
	initial begin : sink_stall
		int hold;
		hold     = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				m_tready = 1'b0;
				hold--;
			end else begin
				m_tready = 1'b1;
				if ($urandom_range(0, 2) == 0) begin
					hold = pick_gap();
				end
			end
		end
	end

	// Every accepted result word is matched against the oldest expectation.
	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.payload_valid = m_tuser[0];
			got.payload_byte  = m_tdata[7:0];
			got.reply_valid   = m_tuser[1];
			got.reply_byte    = m_tdata[15:8];
			got.frame_done    = m_tlast;
			got.status        = m_tdata[18:16];
			if (due_results.size() == 0) begin
				log_error($sformatf("result with none expected: %s", show_result(got)));
			end else begin
				want = due_results.pop_front();
				if (got !== want) begin
					log_error($sformatf("expected %s, got %s", show_result(want),
						show_result(got)));
				end
			end
		end
	end

	initial begin : stimulus
		op_t        op;
		logic [7:0] b;
		int         n;
		result_t    none;
		stim_row_t  row;

		none     = '0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		s_tuser  = OP_BYTE;
		wr_en    = 1'b0;
		wr_index = REG_CHECK_ENABLE;
		wr_data  = 16'h0000;

		// model state after reset
		cfg_check_en  = 1'b1;
		cfg_nonblock  = 1'b0;
		cfg_gap_limit = 16'd1000;
		cfg_ok_code   = 8'h00;
		cfg_fail_code = 8'h02;
		rx_phase      = PH_IDLE;
		rx_len        = '0;
		rx_count      = '0;
		rx_crc        = '0;
		rx_gap        = '0;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed table, reset register values first.
		// Junk while idle, then an idle tick that must be ignored.
		directed_rows.push_back(word_row(OP_BYTE, 8'hFF, 1, 1,
			frame_result(1'b0, 8'h00, 1'b0, 8'h00, 1'b1, ST_BAD_HEADER)));
		directed_rows.push_back(word_row(OP_TICK, 8'h00, 1, 0, none));
		// Two-byte frame with a blocking-mode tick inside and a good CRC.
		directed_rows.push_back(word_row(OP_BYTE, HDR_BYTE, 1, 1,
			frame_result(1'b0, 8'h00, 1'b1, HDR_REPLY, 1'b0, ST_OK)));
		directed_rows.push_back(word_row(OP_BYTE, 8'h00, 1, 0, none));
		directed_rows.push_back(word_row(OP_BYTE, 8'h02, 1, 0, none));
		directed_rows.push_back(word_row(OP_BYTE, 8'hFF, 1, 1,
			frame_result(1'b1, 8'hFF, 1'b0, 8'h00, 1'b0, ST_OK)));
		directed_rows.push_back(word_row(OP_TICK, 8'hFF, 1, 0, none));
		directed_rows.push_back(word_row(OP_BYTE, 8'h00, 1, 1,
			frame_result(1'b1, 8'h00, 1'b0, 8'h00, 1'b0, ST_OK)));
		row      = '0;
		row.kind = ROW_CRC;
		directed_rows.push_back(row);
		directed_rows.push_back(word_row(OP_BYTE, FTR_BYTE, 1, 1,
			frame_result(1'b0, 8'h00, 1'b1, FTR_REPLY, 1'b1, ST_OK)));
		// Zero length: CRC of nothing is 0, then a bad footer.
		directed_rows.push_back(word_row(OP_BYTE, HDR_BYTE, 1, 1,
			frame_result(1'b0, 8'h00, 1'b1, HDR_REPLY, 1'b0, ST_OK)));
		directed_rows.push_back(word_row(OP_BYTE, 8'h00, 1, 0, none));
		directed_rows.push_back(word_row(OP_BYTE, 8'h00, 1, 0, none));
		directed_rows.push_back(word_row(OP_BYTE, 8'h00, 1, 1,
			frame_result(1'b0, 8'h00, 1'b1, 8'h00, 1'b0, ST_OK)));
		directed_rows.push_back(word_row(OP_BYTE, 8'h41, 1, 1,
			frame_result(1'b0, 8'h00, 1'b0, 8'h00, 1'b1, ST_BAD_FOOTER)));
		// One byte 0x80 gives CRC 0x8C; sending 0x00 instead must fail the check.
		directed_rows.push_back(word_row(OP_BYTE, HDR_BYTE, 1, 1,
			frame_result(1'b0, 8'h00, 1'b1, HDR_REPLY, 1'b0, ST_OK)));
		directed_rows.push_back(word_row(OP_BYTE, 8'h00, 1, 0, none));
		directed_rows.push_back(word_row(OP_BYTE, 8'h01, 1, 0, none));
		directed_rows.push_back(word_row(OP_BYTE, 8'h80, 1, 1,
			frame_result(1'b1, 8'h80, 1'b0, 8'h00, 1'b0, ST_OK)));
		directed_rows.push_back(word_row(OP_BYTE, 8'h00, 1, 1,
			frame_result(1'b0, 8'h00, 1'b1, 8'h02, 1'b1, ST_BAD_CHECK)));
		// No CRC, non-blocking with zero gap allowed, codes at the top.
		directed_rows.push_back(cfg_row(REG_CHECK_ENABLE, 16'h0000));
		directed_rows.push_back(cfg_row(REG_NONBLOCKING, 16'h0001));
		directed_rows.push_back(cfg_row(REG_GAP_LIMIT, 16'h0000));
		directed_rows.push_back(cfg_row(REG_OK_CODE, 16'h00FF));
		directed_rows.push_back(cfg_row(REG_FAIL_CODE, 16'h00FF));
		directed_rows.push_back(cfg_row(REG_SPARE, 16'hFFFF));
		// First tick inside a frame times out at once.
		directed_rows.push_back(word_row(OP_BYTE, HDR_BYTE, 1, 1,
			frame_result(1'b0, 8'h00, 1'b1, HDR_REPLY, 1'b0, ST_OK)));
		directed_rows.push_back(word_row(OP_TICK, 8'h00, 1, 1,
			frame_result(1'b0, 8'h00, 1'b0, 8'h00, 1'b1, ST_TIMEOUT)));
		// Zero length with the check off goes straight to the footer.
		directed_rows.push_back(word_row(OP_BYTE, HDR_BYTE, 1, 1,
			frame_result(1'b0, 8'h00, 1'b1, HDR_REPLY, 1'b0, ST_OK)));
		directed_rows.push_back(word_row(OP_BYTE, 8'h00, 1, 0, none));
		directed_rows.push_back(word_row(OP_BYTE, 8'h00, 1, 0, none));
		directed_rows.push_back(word_row(OP_BYTE, FTR_BYTE, 1, 1,
			frame_result(1'b0, 8'h00, 1'b1, FTR_REPLY, 1'b1, ST_OK)));

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			case (row.kind)
				ROW_CFG: begin
					drain_results();
					write_reg(row.reg_idx, row.cfg_val);
				end
				ROW_CRC: put_word(OP_BYTE, rx_crc, 1'b0, 1'b0, none);
				default: put_word(row.op, row.val, row.typed, row.t_has, row.t_res);
			endcase
		end

		// Random phases. Registers change with the block idle, but a frame may
		// still be open across the change, which exercises the late sampling of
		// check_enable.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain_results();
			no_idle = (p == 3);
			write_reg(REG_CHECK_ENABLE, 16'(PHASE_CHECK_EN[p]));
			write_reg(REG_NONBLOCKING, 16'(PHASE_NONBLOCK[p]));
			write_reg(REG_GAP_LIMIT, PHASE_GAP_LIM[p]);
			write_reg(REG_OK_CODE, (p == 0) ? 16'h00FF : 16'($urandom_range(0, 255)));
			write_reg(REG_FAIL_CODE, (p == 0) ? 16'h0000 : 16'($urandom_range(0, 255)));
			n = 0;
			// don't leave a half-read length or a long frame to the next settings
			while (n < WORDS_PER_PHASE || rx_phase == PH_LEN_HI || rx_phase == PH_LEN_LO ||
				(rx_phase == PH_DATA && rx_len > 16'd255)) begin
				pick_word(op, b);
				put_word(op, b, 1'b0, 1'b0, none);
				n++;
				if ($urandom_range(0, 199) == 0) begin
					drain_results(); // sender holds off until the output side is empty
				end
			end
		end
		tick_burst = 0;

		@(negedge clk);
		s_tvalid = 1'b0;
		while (due_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES * 4) @(negedge clk);
		if (errors == 0 && due_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
